// ===== rtl/core/diff_drive_odometry_rk2_top_assert.svh =====
`ifndef DIFF_DRIVE_ODOMETRY_RK2_TOP_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_RK2_TOP_ASSERT_SVH

// same-cycle implication, muted while reset is low
`define DDO_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("odometry check failed");

// next-cycle implication, muted while reset is low
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("odometry check failed");

`endif

// ===== rtl/core/ddo_rk2_pkg.sv =====
`default_nettype none

package ddo_rk2_pkg;

	localparam int IN_W   = 48;
	localparam int OUT_W  = 112;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 32;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [IDX_W-1:0] CFG_TICK_PERIOD   = 2'd0;
	localparam logic [IDX_W-1:0] CFG_WHEEL_RADIUS  = 2'd1;
	localparam logic [IDX_W-1:0] CFG_INVERSE_TRACK = 2'd2;

	localparam logic [CFG_W-1:0] TICK_PERIOD_RST   = 16'd328;
	localparam logic [CFG_W-1:0] WHEEL_RADIUS_RST  = 16'd6554;
	localparam logic [CFG_W-1:0] INVERSE_TRACK_RST = 16'd10240;

	// cordic gain 0.60725 in q.30, and 2^32/(2*pi)
	localparam logic signed [31:0] GAIN_Q30     = 32'sd652032874;
	localparam logic signed [31:0] TURN_PER_RAD = 32'sd683565276;

	localparam int ATAN_COUNT = 24;
	localparam int ATAN_IDX_W = 5;

	// arctan(2^-i) in q0.32 turns
	localparam logic [31:0] ATAN_TURNS [ATAN_COUNT] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_VP_M, ST_VP_R,
		ST_DR_M, ST_DR_R,
		ST_W_M, ST_YAW_R, ST_W16_R,
		ST_HD_M, ST_HD_R,
		ST_HF_M, ST_HF_R,
		ST_VDT_M, ST_VDT_R,
		ST_V16_M, ST_V16_R,
		ST_COR_INIT, ST_COR_STEP,
		ST_PX_M, ST_PX_R, ST_PY_M, ST_PY_R,
		ST_VX_M, ST_VX_R, ST_VY_M, ST_VY_R,
		ST_OUT
	} ddo_state_t;

	function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
		logic fits;
		fits = (v[PROD_W-1:15] == {(PROD_W-15){v[PROD_W-1]}});
		if (fits) begin
			return v[15:0];
		end else if (v[PROD_W-1]) begin
			return 16'sh8000;
		end else begin
			return 16'sh7fff;
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/diff_drive_odometry_rk2_top.sv =====
// differential drive odometry, second-order runge-kutta, fixed point
// input beat on s_axis: left and right wheel speeds (q7.8) and heading
// (binary angle, one turn = 2^16). output beat on m_axis: saturated
// position x/y (q15.16), world velocity x/y (q7.8) and yaw rate (q7.8).
// cfg_we/cfg_index/cfg_wdata write tick_period (0), wheel_radius (1) and
// inverse_track (2); write them only while the block is idle.
// one shared 34x32 multiplier with a rounding shifter and one cordic unit
// doing one rotation a cycle run every tick in turn. the cordic runs twice
// per beat, which sets the pace: a new input beat is taken only after the
// result of the last one has gone into the output register.
// s_axis_tready is high only while idle. the result sits in an output
// register; a stalled receiver holds it and the block waits at the end of
// the next beat until that register is free.
// reset loads the register defaults, clears both position accumulators and
// drops m_axis_tvalid.
`default_nettype none

module diff_drive_odometry_rk2_top #(
	parameter int POS_BITS     = 32,
	parameter int ANGLE_BITS   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// left_speed, right_speed, heading
	input  wire  [ddo_rk2_pkg::IN_W-1:0]        s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// pos_x, pos_y, vel_x, vel_y, yaw_rate
	output logic [ddo_rk2_pkg::OUT_W-1:0]       m_axis_tdata,
	input  wire                                 cfg_we,
	input  wire  [ddo_rk2_pkg::IDX_W-1:0]       cfg_index,
	input  wire  [ddo_rk2_pkg::CFG_W-1:0]       cfg_wdata
);

	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam int ACC_W  = ((POS_BITS > 30) ? POS_BITS : 30) + 1;
	localparam int XW     = (POS_BITS > 32) ? POS_BITS : 32;
	localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
	localparam int PW = ddo_rk2_pkg::PROD_W;

	ddo_rk2_pkg::ddo_state_t state_q, state_d;

	logic [15:0] tick_period_q, wheel_radius_q, inverse_track_q;
	logic signed [POS_BITS-1:0] x_acc_q, y_acc_q;
	logic m_valid_q;
	logic pass_q;
	logic neg_q;
	logic [STEP_W-1:0] step_q;

	logic signed [16:0] sum_q, diff_q;
	logic [15:0] h_q;
	logic signed [33:0] vp_q, dr_q, vdt_q;
	logic signed [29:0] w16_q, hd_q;
	logic signed [25:0] v16_q;
	logic signed [15:0] yaw_q, vx_q, vy_q;
	logic [31:0] ang_q;
	logic signed [31:0] x_q, y_q, z_q, cos_q, sin_q;
	logic signed [PW-1:0] p_q;
	logic [ddo_rk2_pkg::OUT_W-1:0] out_q;

	logic signed [ddo_rk2_pkg::MUL_A_W-1:0] mul_a;
	logic signed [ddo_rk2_pkg::MUL_B_W-1:0] mul_b;
	logic signed [PW-1:0] mul_p;
	logic [6:0] rnd_n;
	logic signed [PW-1:0] rnd_sum, rnd_v;

	logic in_acc, load_out, step_last;
	logic signed [31:0] dx, dy, at, xn, yn, zn;
	logic [31:0] ang_in, ang_chk, ang_fold;
	logic signed [POS_BITS-1:0] acc_sel, acc_new;
	logic signed [ACC_W-1:0] acc_sum;
	logic signed [XW-1:0] px_ext, py_ext;
	logic signed [31:0] px_out, py_out;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign step_last = (step_q == STEP_W'(CORDIC_STEPS - 1));
	assign load_out  = (state_q == ddo_rk2_pkg::ST_OUT) && (!m_valid_q || m_axis_tready);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ddo_rk2_pkg::ST_VP_M: begin
				mul_a = 34'(sum_q);
				mul_b = {16'd0, wheel_radius_q};
			end
			ddo_rk2_pkg::ST_DR_M: begin
				mul_a = 34'(diff_q);
				mul_b = {16'd0, wheel_radius_q};
			end
			// kept on through ST_YAW_R as well so both roundings see the same product
			ddo_rk2_pkg::ST_W_M,
			ddo_rk2_pkg::ST_YAW_R: begin
				mul_a = dr_q;
				mul_b = {16'd0, inverse_track_q};
			end
			ddo_rk2_pkg::ST_HD_M: begin
				mul_a = 34'(w16_q);
				mul_b = {16'd0, tick_period_q};
			end
			ddo_rk2_pkg::ST_HF_M: begin
				mul_a = 34'(hd_q);
				mul_b = ddo_rk2_pkg::TURN_PER_RAD;
			end
			ddo_rk2_pkg::ST_VDT_M: begin
				mul_a = vp_q;
				mul_b = {16'd0, tick_period_q};
			end
			ddo_rk2_pkg::ST_V16_M: begin
				mul_a = vp_q;
				mul_b = 32'sd1;
			end
			ddo_rk2_pkg::ST_PX_M: begin
				mul_a = vdt_q;
				mul_b = cos_q;
			end
			ddo_rk2_pkg::ST_PY_M: begin
				mul_a = vdt_q;
				mul_b = sin_q;
			end
			ddo_rk2_pkg::ST_VX_M: begin
				mul_a = 34'(v16_q);
				mul_b = cos_q;
			end
			ddo_rk2_pkg::ST_VY_M: begin
				mul_a = 34'(v16_q);
				mul_b = sin_q;
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// round-half-up right shift of the registered product
	always_comb begin
		unique case (state_q)
			ddo_rk2_pkg::ST_YAW_R: rnd_n = 7'd28;
			ddo_rk2_pkg::ST_W16_R: rnd_n = 7'd20;
			ddo_rk2_pkg::ST_HD_R:  rnd_n = 7'd17;
			ddo_rk2_pkg::ST_HF_R:  rnd_n = 7'd16;
			ddo_rk2_pkg::ST_VDT_R: rnd_n = 7'd17;
			ddo_rk2_pkg::ST_V16_R: rnd_n = 7'd9;
			ddo_rk2_pkg::ST_PX_R,
			ddo_rk2_pkg::ST_PY_R,
			ddo_rk2_pkg::ST_VX_R,
			ddo_rk2_pkg::ST_VY_R:  rnd_n = 7'd38;
			default:               rnd_n = 7'd1;
		endcase
		rnd_sum = p_q + (PW'(1) << (rnd_n - 7'd1));
		rnd_v   = rnd_sum >>> rnd_n;
	end

	// one cordic rotation
	always_comb begin
		dx = x_q >>> step_q;
		dy = y_q >>> step_q;
		at = ddo_rk2_pkg::ATAN_TURNS[ddo_rk2_pkg::ATAN_IDX_W'(step_q)];
		if (!z_q[31]) begin
			xn = x_q - dy;
			yn = y_q + dx;
			zn = z_q - at;
		end else begin
			xn = x_q + dy;
			yn = y_q - dx;
			zn = z_q + at;
		end
	end

	// fold the angle into [-1/4, 1/4) turn
	always_comb begin
		ang_in   = pass_q ? ({h_q, 16'd0} & ANG_MASK) : ang_q;
		ang_chk  = ang_in + 32'h4000_0000;
		ang_fold = ang_chk[31] ? (ang_in + 32'h8000_0000) : ang_in;
	end

	// saturating position update
	always_comb begin
		acc_sel = (state_q == ddo_rk2_pkg::ST_PY_R) ? y_acc_q : x_acc_q;
		acc_sum = ACC_W'(acc_sel) + ACC_W'(rnd_v);
		if (acc_sum[ACC_W-1:POS_BITS-1] == {(ACC_W-POS_BITS+1){acc_sum[ACC_W-1]}}) begin
			acc_new = acc_sum[POS_BITS-1:0];
		end else if (acc_sum[ACC_W-1]) begin
			acc_new = {1'b1, {(POS_BITS-1){1'b0}}};
		end else begin
			acc_new = {1'b0, {(POS_BITS-1){1'b1}}};
		end
	end

	// position saturated to the 32-bit port
	always_comb begin
		px_ext = XW'(x_acc_q);
		py_ext = XW'(y_acc_q);
		if (px_ext[XW-1:31] == {(XW-31){px_ext[XW-1]}}) begin
			px_out = px_ext[31:0];
		end else begin
			px_out = px_ext[XW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		if (py_ext[XW-1:31] == {(XW-31){py_ext[XW-1]}}) begin
			py_out = py_ext[31:0];
		end else begin
			py_out = py_ext[XW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
	end

	// sequencer
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ddo_rk2_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ddo_rk2_pkg::ST_VP_M;
				end
			end
			ddo_rk2_pkg::ST_VP_M:  state_d = ddo_rk2_pkg::ST_VP_R;
			ddo_rk2_pkg::ST_VP_R:  state_d = ddo_rk2_pkg::ST_DR_M;
			ddo_rk2_pkg::ST_DR_M:  state_d = ddo_rk2_pkg::ST_DR_R;
			ddo_rk2_pkg::ST_DR_R:  state_d = ddo_rk2_pkg::ST_W_M;
			ddo_rk2_pkg::ST_W_M:   state_d = ddo_rk2_pkg::ST_YAW_R;
			ddo_rk2_pkg::ST_YAW_R: state_d = ddo_rk2_pkg::ST_W16_R;
			ddo_rk2_pkg::ST_W16_R: state_d = ddo_rk2_pkg::ST_HD_M;
			ddo_rk2_pkg::ST_HD_M:  state_d = ddo_rk2_pkg::ST_HD_R;
			ddo_rk2_pkg::ST_HD_R:  state_d = ddo_rk2_pkg::ST_HF_M;
			ddo_rk2_pkg::ST_HF_M:  state_d = ddo_rk2_pkg::ST_HF_R;
			ddo_rk2_pkg::ST_HF_R:  state_d = ddo_rk2_pkg::ST_VDT_M;
			ddo_rk2_pkg::ST_VDT_M: state_d = ddo_rk2_pkg::ST_VDT_R;
			ddo_rk2_pkg::ST_VDT_R: state_d = ddo_rk2_pkg::ST_V16_M;
			ddo_rk2_pkg::ST_V16_M: state_d = ddo_rk2_pkg::ST_V16_R;
			ddo_rk2_pkg::ST_V16_R: state_d = ddo_rk2_pkg::ST_COR_INIT;
			ddo_rk2_pkg::ST_COR_INIT: state_d = ddo_rk2_pkg::ST_COR_STEP;
			ddo_rk2_pkg::ST_COR_STEP: begin
				if (step_last) begin
					state_d = pass_q ? ddo_rk2_pkg::ST_VX_M : ddo_rk2_pkg::ST_PX_M;
				end
			end
			ddo_rk2_pkg::ST_PX_M:  state_d = ddo_rk2_pkg::ST_PX_R;
			ddo_rk2_pkg::ST_PX_R:  state_d = ddo_rk2_pkg::ST_PY_M;
			ddo_rk2_pkg::ST_PY_M:  state_d = ddo_rk2_pkg::ST_PY_R;
			ddo_rk2_pkg::ST_PY_R:  state_d = ddo_rk2_pkg::ST_COR_INIT;
			ddo_rk2_pkg::ST_VX_M:  state_d = ddo_rk2_pkg::ST_VX_R;
			ddo_rk2_pkg::ST_VX_R:  state_d = ddo_rk2_pkg::ST_VY_M;
			ddo_rk2_pkg::ST_VY_M:  state_d = ddo_rk2_pkg::ST_VY_R;
			ddo_rk2_pkg::ST_VY_R:  state_d = ddo_rk2_pkg::ST_OUT;
			ddo_rk2_pkg::ST_OUT: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = ddo_rk2_pkg::ST_IDLE;
				end
			end
			default: state_d = ddo_rk2_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddo_rk2_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state, registers and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_q   <= ddo_rk2_pkg::TICK_PERIOD_RST;
			wheel_radius_q  <= ddo_rk2_pkg::WHEEL_RADIUS_RST;
			inverse_track_q <= ddo_rk2_pkg::INVERSE_TRACK_RST;
			x_acc_q         <= '0;
			y_acc_q         <= '0;
			m_valid_q       <= 1'b0;
			pass_q          <= 1'b0;
			neg_q           <= 1'b0;
			step_q          <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ddo_rk2_pkg::CFG_TICK_PERIOD:   tick_period_q   <= cfg_wdata;
					ddo_rk2_pkg::CFG_WHEEL_RADIUS:  wheel_radius_q  <= cfg_wdata;
					ddo_rk2_pkg::CFG_INVERSE_TRACK: inverse_track_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (in_acc) begin
				pass_q <= 1'b0;
			end
			if (state_q == ddo_rk2_pkg::ST_PY_R) begin
				pass_q <= 1'b1;
			end
			if (state_q == ddo_rk2_pkg::ST_COR_INIT) begin
				neg_q  <= ang_chk[31];
				step_q <= '0;
			end
			if (state_q == ddo_rk2_pkg::ST_COR_STEP) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (state_q == ddo_rk2_pkg::ST_PX_R) begin
				x_acc_q <= acc_new;
			end
			if (state_q == ddo_rk2_pkg::ST_PY_R) begin
				y_acc_q <= acc_new;
			end
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		p_q <= mul_p;
		if (in_acc) begin
			sum_q  <= 17'(signed'(s_axis_tdata[31:16])) + 17'(signed'(s_axis_tdata[15:0]));
			diff_q <= 17'(signed'(s_axis_tdata[31:16])) - 17'(signed'(s_axis_tdata[15:0]));
			h_q    <= s_axis_tdata[47:32];
		end
		unique case (state_q)
			ddo_rk2_pkg::ST_VP_R:  vp_q  <= p_q[33:0];
			ddo_rk2_pkg::ST_DR_R:  dr_q  <= p_q[33:0];
			ddo_rk2_pkg::ST_YAW_R: yaw_q <= ddo_rk2_pkg::sat16(rnd_v);
			ddo_rk2_pkg::ST_W16_R: w16_q <= rnd_v[29:0];
			ddo_rk2_pkg::ST_HD_R:  hd_q  <= rnd_v[29:0];
			ddo_rk2_pkg::ST_HF_R:  ang_q <= ({h_q, 16'd0} + rnd_v[31:0]) & ANG_MASK;
			ddo_rk2_pkg::ST_VDT_R: vdt_q <= rnd_v[33:0];
			ddo_rk2_pkg::ST_V16_R: v16_q <= rnd_v[25:0];
			ddo_rk2_pkg::ST_COR_INIT: begin
				x_q <= ddo_rk2_pkg::GAIN_Q30;
				y_q <= '0;
				z_q <= signed'(ang_fold);
			end
			ddo_rk2_pkg::ST_COR_STEP: begin
				x_q <= xn;
				y_q <= yn;
				z_q <= zn;
				if (step_last) begin
					cos_q <= neg_q ? -xn : xn;
					sin_q <= neg_q ? -yn : yn;
				end
			end
			ddo_rk2_pkg::ST_VX_R: vx_q <= ddo_rk2_pkg::sat16(rnd_v);
			ddo_rk2_pkg::ST_VY_R: vy_q <= ddo_rk2_pkg::sat16(rnd_v);
			default: begin
			end
		endcase
		if (load_out) begin
			out_q <= {yaw_q, vy_q, vx_q, py_out, px_out};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/ddo_rk2_chk.sv =====
`default_nettype none

`include "diff_drive_odometry_rk2_top_assert.svh"

module ddo_rk2_chk (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               s_axis_tvalid,
	input wire                               s_axis_tready,
	input wire                               m_axis_tvalid,
	input wire                               m_axis_tready,
	input wire [ddo_rk2_pkg::OUT_W-1:0]      m_axis_tdata
);

	logic in_beat;
	logic out_stall;

	assign in_beat   = s_axis_tvalid && s_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	// one beat at a time: busy right after taking an input
	`DDO_ASSERT_NEXT(busy_after_in, clk, arst_n, in_beat, !s_axis_tready)
	// a new result only appears as the sequencer returns from its busy stretch
	`DDO_ASSERT_SAME(result_after_busy, clk, arst_n, $rose(m_axis_tvalid), $past(!s_axis_tready))
	// a result never first shows right after an input is taken
	`DDO_ASSERT_NEXT(no_in_at_result, clk, arst_n, in_beat, !$rose(m_axis_tvalid))
	`DDO_ASSERT_NEXT(out_valid_hold, clk, arst_n, out_stall, m_axis_tvalid)
	`DDO_ASSERT_NEXT(out_data_hold, clk, arst_n, out_stall, $stable(m_axis_tdata))

endmodule

bind diff_drive_odometry_rk2_top ddo_rk2_chk u_ddo_rk2_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
